// ----- design/assert_macros.svh -----
// Assertion macros for the move request window tracker.
// Included by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, ignored while reset is high.
`define ASSERT_CLK(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- design/mrwt_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the move request window tracker.
// No dependencies.
package mrwt_pkg;

  localparam int KEY_COUNT = 6;
  localparam int KEY_W     = 32;
  localparam int KP_W      = 3;
  localparam int SEQ_W     = 8;
  localparam int DIR_W     = 8;

  typedef enum logic [1:0] {
    KIND_MOVE     = 2'd0,
    KIND_ACCEPT   = 2'd1,
    KIND_DENY     = 2'd2,
    KIND_PUSH_KEY = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SHIFT
  } state_t;

  // per-cell controls: load wins over shift
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

// ----- design/mrwt_cell.sv -----
`timescale 1ns / 1ps
// One storage cell of a chain: load a value or take the neighbor's value.
// Depends on mrwt_pkg (cell_ctrl_t).
module mrwt_cell import mrwt_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  cell_ctrl_t   ctrl,
  input  logic [W-1:0] load_data,
  input  logic [W-1:0] shift_data,
  output logic [W-1:0] data
);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      data <= load_data;
    end else if (ctrl.shift) begin
      data <= shift_data;
    end
  end

endmodule

// ----- design/move_request_window_tracker_top.sv -----
`timescale 1ns / 1ps
// Top level of the move request window tracker: control, window and key chains.
// Depends on mrwt_pkg, mrwt_cell and assert_macros.svh.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  in      | input     | in_valid / in_ready | kind, direction, ack_sequence, key_value
//  out     | output    | out_valid/out_ready | request_sent, sent_direction,
//          |           |                     | sent_sequence, sent_key, ack_matched,
//          |           |                     | pending_count
//
// Steps: a move request, deny, push key or unmatched accept is taken in ST_IDLE
//   and executed in ST_EXEC. A matched accept then moves to ST_SHIFT: the window
//   chain pops one entry per cycle from its head until the match leaves; the pop
//   of the match waits while the output register is still full.
// Reset (rst, synchronous): sequence counter, key pointer, key-written flags and fill
//   count clear, so unwritten key slots read as zero; window cells are not cleared.
// Stalls: the result sits in an output register; the block takes the next
//   transfer while it waits and only holds before writing a new result.
module move_request_window_tracker_top import mrwt_pkg::*; #(
  parameter int WINDOW_DEPTH = 16,
  localparam int CW = $clog2(WINDOW_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  // input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        kind,
  input  logic [DIR_W-1:0]  direction,
  input  logic [SEQ_W-1:0]  ack_sequence,
  input  logic [KEY_W-1:0]  key_value,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic              request_sent,
  output logic [DIR_W-1:0]  sent_direction,
  output logic [SEQ_W-1:0]  sent_sequence,
  output logic [KEY_W-1:0]  sent_key,
  output logic              ack_matched,
  output logic [CW-1:0]     pending_count
);

`include "assert_macros.svh"

  // ---------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------
  state_t             state, state_next;
  logic [SEQ_W-1:0]   next_seq, next_seq_next;
  logic [KP_W-1:0]    key_pointer, key_pointer_next;
  logic [CW-1:0]      total, total_next;

  // latched input transfer
  kind_t              item_kind;
  logic [DIR_W-1:0]   item_dir;
  logic [SEQ_W-1:0]   item_ack;
  logic [KEY_W-1:0]   item_key;

  // result being written to the output register this cycle
  logic               produce;
  logic               slot_free;
  logic               res_sent;
  logic [DIR_W-1:0]   res_dir;
  logic [SEQ_W-1:0]   res_seq;
  logic [KEY_W-1:0]   res_key;
  logic               res_matched;

  // chain controls
  logic               win_append;
  logic               win_shift;
  logic               key_push;

  // ---------------------------------------------------------------------
  // Window chain: cell 0 is the oldest outstanding request. Entries at or
  // beyond the fill count hold stale data and are masked off the compare.
  // ---------------------------------------------------------------------
  logic [SEQ_W-1:0]        win_data [WINDOW_DEPTH];
  cell_ctrl_t              win_ctrl [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] win_hit;
  logic                    any_hit;

  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_win
    logic [SEQ_W-1:0] shift_src;
    if (i == WINDOW_DEPTH - 1) begin : g_last
      assign shift_src = win_data[i];
    end else begin : g_mid
      assign shift_src = win_data[i+1];
    end

    assign win_ctrl[i].load  = win_append && (total == CW'(i));
    assign win_ctrl[i].shift = win_shift;
    assign win_hit[i]        = (win_data[i] == item_ack) && (CW'(i) < total);

    mrwt_cell #(.W(SEQ_W)) u_cell (
      .clk        (clk),
      .ctrl       (win_ctrl[i]),
      .load_data  (next_seq),
      .shift_data (shift_src),
      .data       (win_data[i])
    );
  end

  assign any_hit = |win_hit;

  // ---------------------------------------------------------------------
  // Key chain: push shifts slot i-1 into slot i and the new key into slot 0.
  // ---------------------------------------------------------------------
  logic [KEY_W-1:0] key_data [KEY_COUNT];
  cell_ctrl_t       key_ctrl;
  logic [KEY_W-1:0] cur_key;

  assign key_ctrl.load  = 1'b0;
  assign key_ctrl.shift = key_push;

  for (genvar i = 0; i < KEY_COUNT; i++) begin : g_key
    logic [KEY_W-1:0] shift_src;
    if (i == 0) begin : g_first
      assign shift_src = item_key;
    end else begin : g_rest
      assign shift_src = key_data[i-1];
    end

    mrwt_cell #(.W(KEY_W)) u_cell (
      .clk        (clk),
      .ctrl       (key_ctrl),
      .load_data  ({KEY_W{1'b0}}),
      .shift_data (shift_src),
      .data       (key_data[i])
    );
  end

  // Key slots read as zero until written; a request before any key is loaded must see that.
  logic [KEY_COUNT-1:0] key_written;

  always_comb begin
    cur_key = '0;
    if (key_pointer < KP_W'(KEY_COUNT)) begin
      if (key_written[key_pointer]) begin
        cur_key = key_data[key_pointer];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_written <= '0;
    end else if (key_push) begin
      key_written <= {key_written[KEY_COUNT-2:0], 1'b1};
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next       = state;
    in_ready         = 1'b0;
    produce          = 1'b0;
    res_sent         = 1'b0;
    res_dir          = '0;
    res_seq          = '0;
    res_key          = '0;
    res_matched      = 1'b0;
    win_append       = 1'b0;
    win_shift        = 1'b0;
    key_push         = 1'b0;
    next_seq_next    = next_seq;
    key_pointer_next = key_pointer;
    total_next       = total;

    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end

      ST_EXEC: begin
        case (item_kind)
          KIND_MOVE: begin
            if (slot_free) begin
              produce    = 1'b1;
              state_next = ST_IDLE;
              if (total < CW'(WINDOW_DEPTH)) begin
                res_sent      = 1'b1;
                res_dir       = item_dir;
                res_seq       = next_seq;
                res_key       = cur_key;
                win_append    = 1'b1;
                next_seq_next = next_seq + 1'b1;
                if (key_pointer >= KP_W'(KEY_COUNT - 1)) begin
                  key_pointer_next = '0;
                end else begin
                  key_pointer_next = key_pointer + 1'b1;
                end
                total_next = total + 1'b1;
              end
            end
          end

          KIND_ACCEPT: begin
            if (any_hit) begin
              state_next = ST_SHIFT;
            end else if (slot_free) begin
              produce    = 1'b1;
              state_next = ST_IDLE;
            end
          end

          KIND_DENY: begin
            if (slot_free) begin
              produce          = 1'b1;
              state_next       = ST_IDLE;
              next_seq_next    = '0;
              key_pointer_next = '0;
              total_next       = '0;
            end
          end

          KIND_PUSH_KEY: begin
            if (slot_free) begin
              produce    = 1'b1;
              state_next = ST_IDLE;
              key_push   = 1'b1;
            end
          end

          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end

      ST_SHIFT: begin
        // pop the oldest entry each cycle, the match only once the output register is free; its pop ends the item
        if (win_data[0] != item_ack) begin
          win_shift  = 1'b1;
          total_next = total - 1'b1;
        end else if (slot_free) begin
          win_shift   = 1'b1;
          total_next  = total - 1'b1;
          produce     = 1'b1;
          res_matched = 1'b1;
          state_next  = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      next_seq    <= '0;
      key_pointer <= '0;
      total       <= '0;
    end else begin
      state       <= state_next;
      next_seq    <= next_seq_next;
      key_pointer <= key_pointer_next;
      total       <= total_next;
    end
  end

  // input transfer capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_kind <= kind_t'(kind);
      item_dir  <= direction;
      item_ack  <= ack_sequence;
      item_key  <= key_value;
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (produce) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      request_sent   <= res_sent;
      sent_direction <= res_dir;
      sent_sequence  <= res_seq;
      sent_key       <= res_key;
      ack_matched    <= res_matched;
      pending_count  <= total_next;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `ASSERT_CLK(a_fill_bound, clk, rst, total <= CW'(WINDOW_DEPTH), "window fill count overflow")
  `ASSERT_CLK(a_shift_nonempty, clk, rst, (state == ST_SHIFT) |-> (total != '0), "pop from empty window")
  `ASSERT_CLK(a_key_ptr_range, clk, rst, key_pointer < KP_W'(KEY_COUNT), "key pointer out of range")
  `ASSERT_CLK(a_sent_counts, clk, rst, (out_valid && request_sent) |-> (pending_count != '0), "issued request not counted")

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for move_request_window_tracker_top: directed table, then random traffic.
// Needs mrwt_pkg and the RTL of the block; an internal predictor supplies expected results.
module tb;
  import mrwt_pkg::*;

  localparam int WINDOW_DEPTH = 16;
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int HOLD_CYCLES  = 200;  // long receiver hold-off in the pressure phase
  localparam int TAIL_CYCLES  = 40;   // idle tail before the summary
  localparam int LIMIT_NS     = 5_000_000;
  localparam int PRINT_CAP    = 50;

  // One result transfer, field for field as on the ports.
  typedef struct packed {
    logic             sent;
    logic [DIR_W-1:0] dir;
    logic [SEQ_W-1:0] seq;
    logic [KEY_W-1:0] key;
    logic             matched;
    logic [CNT_W-1:0] pending;
  } move_result_t;

  // Hand-written expectation for a table row; typed = 0 means use the predictor.
  typedef struct packed {
    logic         typed;
    move_result_t want;
  } typed_exp_t;

  typedef struct packed {
    kind_t            kind;
    logic [DIR_W-1:0] dir;
    logic [SEQ_W-1:0] ack;
    logic [KEY_W-1:0] key;
    logic [4:0]       reps;
    typed_exp_t       te;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        kind;
  logic [DIR_W-1:0]  direction;
  logic [SEQ_W-1:0]  ack_sequence;
  logic [KEY_W-1:0]  key_value;
  logic              out_valid;
  logic              out_ready;
  logic              request_sent;
  logic [DIR_W-1:0]  sent_direction;
  logic [SEQ_W-1:0]  sent_sequence;
  logic [KEY_W-1:0]  sent_key;
  logic              ack_matched;
  logic [CNT_W-1:0]  pending_count;

  move_request_window_tracker_top #(.WINDOW_DEPTH(WINDOW_DEPTH)) DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .direction      (direction),
    .ack_sequence   (ack_sequence),
    .key_value      (key_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .request_sent   (request_sent),
    .sent_direction (sent_direction),
    .sent_sequence  (sent_sequence),
    .sent_key       (sent_key),
    .ack_matched    (ack_matched),
    .pending_count  (pending_count)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: sequence counter, rotating key index, key slots and the
  // window of outstanding sequences (oldest at the front).
  // ---------------------------------------------------------------------------
  logic [SEQ_W-1:0] seq_ctr;
  int               key_idx;
  logic [KEY_W-1:0] key_ring [KEY_COUNT];
  logic [SEQ_W-1:0] window_q [$];

  move_result_t expected_results [$];
  typed_exp_t   typed_q [$];     // one entry per offered transfer, in order
  stim_row_t    directed_rows [$];

  int mismatch_count = 0;
  int items_taken    = 0;
  int results_seen   = 0;
  int issued = 0, refused = 0, acks_hit = 0, acks_missed = 0;
  int denies = 0, key_pushes = 0, seq_wraps = 0, peak_fill = 0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  logic hold_req = 1'b0;
  int   hold_left = 0;

  task automatic report_error(string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) $display("%0t: %s", $realtime, msg);
  endtask

  // Expected result of one transfer; advances the predictor state.
  function automatic move_result_t track_item(kind_t k, logic [DIR_W-1:0] dir,
                                              logic [SEQ_W-1:0] ack, logic [KEY_W-1:0] key);
    move_result_t r;
    int hit;
    r = '0;
    hit = -1;
    case (k)
      KIND_MOVE: begin
        if (window_q.size() < WINDOW_DEPTH) begin
          r.sent = 1'b1;
          r.dir  = dir;
          r.seq  = seq_ctr;
          r.key  = key_ring[key_idx];
          window_q.push_back(seq_ctr);
          if (seq_ctr == '1) seq_wraps++;
          seq_ctr = seq_ctr + 1'b1;
          key_idx = (key_idx == KEY_COUNT - 1) ? 0 : key_idx + 1;
          issued++;
        end else begin
          refused++;  // window full: nothing changes
        end
      end
      KIND_ACCEPT: begin
        // oldest matching entry wins; it and everything older leave the window
        foreach (window_q[i]) if (hit < 0 && window_q[i] == ack) hit = i;
        if (hit >= 0) begin
          r.matched = 1'b1;
          repeat (hit + 1) void'(window_q.pop_front());
          acks_hit++;
        end else begin
          acks_missed++;
        end
      end
      KIND_DENY: begin
        // key slots survive a deny
        seq_ctr = '0;
        key_idx = 0;
        window_q.delete();
        denies++;
      end
      default: begin
        for (int i = KEY_COUNT - 1; i > 0; i--) key_ring[i] = key_ring[i - 1];
        key_ring[0] = key;
        key_pushes++;
      end
    endcase
    if (window_q.size() > peak_fill) peak_fill = window_q.size();
    r.pending = CNT_W'(window_q.size());
    return r;
  endfunction

  task automatic check_result(move_result_t got, move_result_t want);
    if (got.sent !== want.sent)
      report_error($sformatf("result %0d request_sent %0h, expected %0h",
                             results_seen, got.sent, want.sent));
    if (got.dir !== want.dir)
      report_error($sformatf("result %0d sent_direction %0h, expected %0h",
                             results_seen, got.dir, want.dir));
    if (got.seq !== want.seq)
      report_error($sformatf("result %0d sent_sequence %0h, expected %0h",
                             results_seen, got.seq, want.seq));
    if (got.key !== want.key)
      report_error($sformatf("result %0d sent_key %0h, expected %0h",
                             results_seen, got.key, want.key));
    if (got.matched !== want.matched)
      report_error($sformatf("result %0d ack_matched %0h, expected %0h",
                             results_seen, got.matched, want.matched));
    if (got.pending !== want.pending)
      report_error($sformatf("result %0d pending_count %0d, expected %0d",
                             results_seen, got.pending, want.pending));
  endtask

  // ---------------------------------------------------------------------------
  // Monitor. All drivers use nonblocking updates, so values read right after
  // the edge are the ones the block saw at that edge. Input transfers are
  // handled before output transfers: an item never completes at the edge
  // that takes it, so its expectation is always queued first.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    move_result_t want;
    move_result_t got;
    typed_exp_t   te;
    if (!rst) begin
      if (in_valid && in_ready) begin
        want = track_item(kind_t'(kind), direction, ack_sequence, key_value);
        if (typed_q.size() > 0) begin
          te = typed_q.pop_front();
          if (te.typed) want = te.want;
        end
        expected_results.push_back(want);
        items_taken++;
      end
      if (out_valid && out_ready) begin
        got.sent    = request_sent;
        got.dir     = sent_direction;
        got.seq     = sent_sequence;
        got.key     = sent_key;
        got.matched = ack_matched;
        got.pending = pending_count;
        if (expected_results.size() == 0)
          report_error($sformatf("result transfer with nothing outstanding (pending_count %0d)",
                                 pending_count));
        else
          check_result(got, expected_results.pop_front());
        results_seen++;
      end
    end
  end

  // Receiver: random stalls, plus one long counted hold-off on request so the
  // block backs up and stalls its input.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one transfer; returns at the edge where it is taken. A random gap
  // drops valid first; back-to-back items keep valid high with one update.
  task automatic offer(kind_t k, logic [DIR_W-1:0] dir, logic [SEQ_W-1:0] ack,
                       logic [KEY_W-1:0] key, typed_exp_t te);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    typed_q.push_back(te);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    kind         <= k;
    direction    <= dir;
    ack_sequence <= ack;
    key_value    <= key;
    do @(posedge clk); while (!in_ready);
  endtask

  // Sender pause: valid low until every expected result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic move_result_t res(logic s, logic [DIR_W-1:0] d, logic [SEQ_W-1:0] q,
                                       logic [KEY_W-1:0] k, logic m, logic [CNT_W-1:0] p);
    move_result_t r;
    r.sent = s; r.dir = d; r.seq = q; r.key = k; r.matched = m; r.pending = p;
    return r;
  endfunction

  function automatic stim_row_t row(kind_t k, logic [DIR_W-1:0] d, logic [SEQ_W-1:0] a,
                                    logic [KEY_W-1:0] key, int reps, logic typed,
                                    move_result_t want);
    stim_row_t r;
    r.kind = k; r.dir = d; r.ack = a; r.key = key; r.reps = 5'(reps);
    r.te.typed = typed; r.te.want = want;
    return r;
  endfunction

  // Watchdog
  initial begin
    #(LIMIT_NS);
    $display("[move_request_window_tracker_top] ERROR");
    $finish;
  end

  initial begin
    typed_exp_t       no_te;
    kind_t            rk;
    logic [DIR_W-1:0] rdir;
    logic [SEQ_W-1:0] rack;
    logic [KEY_W-1:0] rkey;
    int               r, n_items, move_pct;
    logic             deny_ok;

    no_te        = '0;
    rst          = 1'b1;
    in_valid     = 1'b0;
    kind         = KIND_MOVE;
    direction    = '0;
    ack_sequence = '0;
    key_value    = '0;
    out_ready    = 1'b0;

    seq_ctr = '0;
    key_idx = 0;
    foreach (key_ring[i]) key_ring[i] = '0;

    // Directed table. Typed rows can be read straight off the behavior;
    // the rest go through the predictor.
    // first requests after reset: sequences 0 and 1, key slots still zero
    directed_rows.push_back(row(KIND_MOVE, 8'h00, 8'h00, '0, 1, 1,
                                res(1, 8'h00, 8'h00, '0, 0, 1)));
    directed_rows.push_back(row(KIND_MOVE, 8'hFF, 8'h00, '0, 1, 1,
                                res(1, 8'hFF, 8'h01, '0, 0, 2)));
    // unmatched accept is ignored, then accept of the oldest
    directed_rows.push_back(row(KIND_ACCEPT, 8'h00, 8'h55, '0, 1, 1, res(0, 0, 0, 0, 0, 2)));
    directed_rows.push_back(row(KIND_ACCEPT, 8'h00, 8'h00, '0, 1, 1, res(0, 0, 0, 0, 1, 1)));
    // key pushes: all-ones, all-zeros, mixed
    directed_rows.push_back(row(KIND_PUSH_KEY, 8'h00, 8'h00, 32'hFFFF_FFFF, 1, 1,
                                res(0, 0, 0, 0, 0, 1)));
    directed_rows.push_back(row(KIND_PUSH_KEY, 8'h00, 8'h00, 32'h0, 1, 0, '0));
    directed_rows.push_back(row(KIND_PUSH_KEY, 8'h00, 8'h00, 32'hA5A5_5A5A, 1, 0, '0));
    directed_rows.push_back(row(KIND_MOVE, 8'h3C, 8'h00, '0, 1, 0, '0));
    directed_rows.push_back(row(KIND_ACCEPT, 8'h00, 8'hFF, '0, 1, 0, '0));
    // deny empties the window but keeps the key slots
    directed_rows.push_back(row(KIND_DENY, 8'h00, 8'h00, '0, 1, 1, res(0, 0, 0, 0, 0, 0)));
    directed_rows.push_back(row(KIND_MOVE, 8'h81, 8'h00, '0, 1, 0, '0));
    // fill the window, then one request too many is refused
    directed_rows.push_back(row(KIND_MOVE, 8'hC3, 8'h00, '0, WINDOW_DEPTH - 1, 0, '0));
    directed_rows.push_back(row(KIND_MOVE, 8'h7E, 8'h00, '0, 1, 1,
                                res(0, 0, 0, 0, 0, CNT_W'(WINDOW_DEPTH))));
    // accept of the newest entry clears the whole window (slowest case)
    directed_rows.push_back(row(KIND_ACCEPT, 8'h00, 8'h0F, '0, 1, 1, res(0, 0, 0, 0, 1, 0)));
    directed_rows.push_back(row(KIND_ACCEPT, 8'h00, 8'h0F, '0, 1, 1, res(0, 0, 0, 0, 0, 0)));
    // six requests walk the key pointer round once; then a mid-window accept
    directed_rows.push_back(row(KIND_MOVE, 8'h01, 8'h00, '0, KEY_COUNT, 0, '0));
    directed_rows.push_back(row(KIND_ACCEPT, 8'h00, 8'h12, '0, 1, 0, '0));
    directed_rows.push_back(row(KIND_PUSH_KEY, 8'h00, 8'h00, 32'h0000_0001, 1, 0, '0));
    directed_rows.push_back(row(KIND_DENY, 8'h00, 8'h00, '0, 1, 1, res(0, 0, 0, 0, 0, 0)));
    directed_rows.push_back(row(KIND_ACCEPT, 8'h00, 8'h00, '0, 1, 1, res(0, 0, 0, 0, 0, 0)));

    // single reset at the start of the run
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part under light idling on both sides
    send_idle_pct  = 28;
    recv_stall_pct = 28;
    foreach (directed_rows[i])
      repeat (directed_rows[i].reps)
        offer(directed_rows[i].kind, directed_rows[i].dir, directed_rows[i].ack,
              directed_rows[i].key, directed_rows[i].te);
    drain();

    // Random phases. The early ones carry no deny so the sequence counter
    // runs past 255; later ones add denies and the long receiver hold-off.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  n_items = 400; move_pct = 50;
                 deny_ok = 1'b0; end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  n_items = 400; move_pct = 65;
                 deny_ok = 1'b0; end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; n_items = 300; move_pct = 50;
                 deny_ok = 1'b1; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; n_items = 300;
                 move_pct = 55; deny_ok = 1'b1; end
      endcase
      for (int n = 0; n < n_items; n++) begin
        // back-pressure: receiver goes quiet while the sender keeps offering
        if (p == 2 && n == 40) hold_req = 1'b1;
        rdir = $urandom;
        rack = $urandom;
        rkey = $urandom;
        r    = $urandom_range(99);
        if (r < move_pct) begin
          rk = KIND_MOVE;
        end else if (r < move_pct + 30) begin
          rk = KIND_ACCEPT;
          // mostly acks of outstanding entries, usually the oldest
          if (window_q.size() > 0 && $urandom_range(99) < 85) begin
            if ($urandom_range(99) < 60) rack = window_q[0];
            else rack = window_q[$urandom_range(window_q.size() - 1)];
          end
        end else if (r < 96 || !deny_ok) begin
          rk = KIND_PUSH_KEY;
        end else begin
          rk = KIND_DENY;
        end
        offer(rk, rdir, rack, rkey, no_te);
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d transfers, %0d results: %0d requests issued,",
             items_taken, results_seen, issued);
    $display("  %0d refused on a full window, %0d/%0d accepts matched/ignored, %0d denies,",
             refused, acks_hit, acks_missed, denies);
    $display("  %0d key pushes, %0d sequence wraps, peak fill %0d.",
             key_pushes, seq_wraps, peak_fill);
    if (mismatch_count == 0) begin
      $display("[move_request_window_tracker_top] OK");
    end else begin
      $display("[move_request_window_tracker_top] ERROR");
    end
    $finish;
  end

endmodule
